>>> rtl/core/kvtp_pkg.sv
`default_nettype none

package kvtp_pkg;

    // Default capacities for the name store and the value length counter.
    localparam int NAME_CAP_DEF  = 32;
    localparam int VALUE_CAP_DEF = 128;

    localparam int CHAR_W = 8;

    // Characters the parser reacts to.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LC_N   = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_LC_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LC_R   = 8'h72;

    // Kind of an output word.
    typedef enum logic [1:0] {
        KIND_NAME     = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_PAIR_END = 2'd2,
        KIND_LINE_END = 2'd3
    } t_kind;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_SKIP     = 3'd0,
        PH_NAME     = 3'd1,
        PH_AFTER_EQ = 3'd2,
        PH_VALUE    = 3'd3,
        PH_QUOTED   = 3'd4
    } t_phase;

    // Sequencer state.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EMIT = 2'd1,
        ST_RD   = 2'd2,
        ST_WAIT = 2'd3
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/kvtp_name_ram.sv
`default_nettype none

module kvtp_name_ram #(
    parameter int DEPTH = kvtp_pkg::NAME_CAP_DEF - 1,
    parameter int AW    = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [kvtp_pkg::CHAR_W-1:0] i_wdata,
    input  wire logic                        i_re,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [kvtp_pkg::CHAR_W-1:0] o_rdata
);

    logic [kvtp_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [kvtp_pkg::CHAR_W-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/key_value_token_parser.sv
`default_nettype none

// Command line tokenizer: takes one byte per word, byte 0 ending the line, and
// emits a stream of name characters, value characters, pair-end and line-end
// words, with out_last marking the final word caused by each byte. A byte that
// causes words is taken first; its words then go out one by one as the output
// register is free to load. The '=' byte replays the stored name from a memory
// with a single registered read port: each name character is read (ST_RD) and
// then loaded into the output register (ST_WAIT). Input is not taken while words
// of the previous byte are still being issued, but the last word may wait in the
// output register while the next byte is taken.
module key_value_token_parser #(
    parameter int NAME_CAP  = kvtp_pkg::NAME_CAP_DEF,
    parameter int VALUE_CAP = kvtp_pkg::VALUE_CAP_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [kvtp_pkg::CHAR_W-1:0] i_in_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [1:0]                  o_out_kind,
    output logic      [kvtp_pkg::CHAR_W-1:0] o_out_char,
    output logic                             o_out_last
);

    localparam int NDEPTH = NAME_CAP - 1;
    localparam int AW     = (NAME_CAP > 2) ? $clog2(NAME_CAP - 1) : 1;
    localparam int LW     = $clog2(NAME_CAP);
    localparam int VW     = $clog2(VALUE_CAP);

    typedef logic [kvtp_pkg::CHAR_W-1:0] t_char;

    // Parser state.
    kvtp_pkg::t_phase r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [LW-1:0]    r_name_len, n_name_len;
    logic [VW-1:0]    r_val_len, n_val_len;
    logic             r_pair, n_pair;

    // Words still to be issued for the byte just taken.
    logic  r_pend_val, r_pend_pair, r_pend_line;
    logic  n_pend_val, n_pend_pair, n_pend_line, n_replay;
    t_char r_pend_char, n_pend_char;

    // Sequencer and replay index.
    kvtp_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_idx;

    // Output register.
    logic             r_out_valid;
    kvtp_pkg::t_kind  r_out_kind;
    t_char            r_out_char;
    logic             r_out_last;

    // Name memory ports.
    logic          dec_we;
    logic [AW-1:0] dec_waddr;
    t_char         ram_rdata;

    // Sequencer control.
    logic            in_acc;
    logic            can_load;
    logic            load_out;
    kvtp_pkg::t_kind load_kind;
    t_char           load_char;
    logic            load_last;
    logic            rd_en;
    logic            clr_val, clr_pair;
    logic            name_last;
    logic            emit_last;

    // Decode helpers.
    t_char b;
    t_char esc_ch;
    logic  is_blank;
    logic  quoted;
    logic  val_path;
    logic  val_room;

    assign in_acc   = i_in_valid && o_in_ready;
    assign can_load = !r_out_valid || i_out_ready;
    assign b        = i_in_byte;
    assign is_blank = (b == kvtp_pkg::CH_SPACE) || (b == kvtp_pkg::CH_TAB);
    assign quoted   = (r_phase == kvtp_pkg::PH_QUOTED);
    assign val_room = r_pair && (r_val_len < VW'(VALUE_CAP - 1));

    // The byte goes through the value decoder in a value phase, or after '='
    // once the first byte that is neither blank nor an opening quote arrives.
    assign val_path = (r_phase == kvtp_pkg::PH_VALUE) || quoted ||
                      ((r_phase == kvtp_pkg::PH_AFTER_EQ) && !is_blank &&
                       (b != kvtp_pkg::CH_QUOTE));

    // Escape translation.
    always_comb begin
        if (b == kvtp_pkg::CH_LC_N) begin
            esc_ch = kvtp_pkg::CH_NL;
        end else if (b == kvtp_pkg::CH_LC_T) begin
            esc_ch = kvtp_pkg::CH_TAB;
        end else if (b == kvtp_pkg::CH_LC_R) begin
            esc_ch = kvtp_pkg::CH_CR;
        end else begin
            esc_ch = b;
        end
    end

    // Byte decode: next parser state, name writes and the words to issue.
    always_comb begin
        n_phase     = r_phase;
        n_esc       = r_esc;
        n_name_len  = r_name_len;
        n_val_len   = r_val_len;
        n_pair      = r_pair;
        n_pend_val  = 1'b0;
        n_pend_pair = 1'b0;
        n_pend_line = 1'b0;
        n_replay    = 1'b0;
        n_pend_char = b;
        dec_we      = 1'b0;
        dec_waddr   = r_name_len[AW-1:0];

        if (val_path) begin
            // Value decoding, shared by the value phases and the first byte
            // after the blanks that follow '='.
            n_phase = quoted ? kvtp_pkg::PH_QUOTED : kvtp_pkg::PH_VALUE;
            if (r_esc) begin
                n_esc = 1'b0;
                if (b == kvtp_pkg::CH_NUL) begin
                    // A trailing backslash stays a literal.
                    n_pend_char = kvtp_pkg::CH_BSLASH;
                    n_pend_val  = val_room;
                    n_val_len   = r_val_len + VW'(val_room);
                    n_pend_pair = r_pair;
                    n_pend_line = 1'b1;
                    n_pair      = 1'b0;
                    n_phase     = kvtp_pkg::PH_SKIP;
                end else begin
                    n_pend_char = esc_ch;
                    n_pend_val  = val_room;
                    n_val_len   = r_val_len + VW'(val_room);
                end
            end else if (b == kvtp_pkg::CH_NUL) begin
                n_pend_pair = r_pair;
                n_pend_line = 1'b1;
                n_pair      = 1'b0;
                n_phase     = kvtp_pkg::PH_SKIP;
            end else if (b == kvtp_pkg::CH_BSLASH) begin
                n_esc = 1'b1;
            end else if ((quoted && (b == kvtp_pkg::CH_QUOTE)) ||
                         (!quoted && is_blank)) begin
                n_pend_pair = r_pair;
                n_pair      = 1'b0;
                n_phase     = kvtp_pkg::PH_SKIP;
            end else begin
                n_pend_val = val_room;
                n_val_len  = r_val_len + VW'(val_room);
            end
        end else begin
            case (r_phase)
                kvtp_pkg::PH_SKIP: begin
                    if (b == kvtp_pkg::CH_NUL) begin
                        n_pend_line = 1'b1;
                        n_esc       = 1'b0;
                        n_pair      = 1'b0;
                    end else if (is_blank) begin
                        n_phase = kvtp_pkg::PH_SKIP;
                    end else if (b == kvtp_pkg::CH_EQ) begin
                        // A pair with an empty name: parsed, never emitted.
                        n_name_len = '0;
                        n_pair     = 1'b0;
                        n_val_len  = '0;
                        n_esc      = 1'b0;
                        n_phase    = kvtp_pkg::PH_AFTER_EQ;
                    end else begin
                        dec_we     = 1'b1;
                        dec_waddr  = '0;
                        n_name_len = LW'(1);
                        n_phase    = kvtp_pkg::PH_NAME;
                    end
                end
                kvtp_pkg::PH_NAME: begin
                    if (b == kvtp_pkg::CH_NUL) begin
                        n_pend_line = 1'b1;
                        n_esc       = 1'b0;
                        n_pair      = 1'b0;
                        n_phase     = kvtp_pkg::PH_SKIP;
                    end else if (is_blank) begin
                        n_phase = kvtp_pkg::PH_SKIP;
                    end else if (b == kvtp_pkg::CH_EQ) begin
                        n_replay  = (r_name_len != '0);
                        n_pair    = (r_name_len != '0);
                        n_val_len = '0;
                        n_esc     = 1'b0;
                        n_phase   = kvtp_pkg::PH_AFTER_EQ;
                    end else if (r_name_len < LW'(NAME_CAP - 1)) begin
                        dec_we     = 1'b1;
                        n_name_len = r_name_len + LW'(1);
                    end
                end
                kvtp_pkg::PH_AFTER_EQ: begin
                    // Blanks are skipped; an opening quote starts a quoted value.
                    if (b == kvtp_pkg::CH_QUOTE) begin
                        n_phase = kvtp_pkg::PH_QUOTED;
                    end
                end
                default: begin
                    n_phase = kvtp_pkg::PH_SKIP;
                    n_esc   = 1'b0;
                end
            endcase
        end
    end

    kvtp_name_ram #(
        .DEPTH (NDEPTH),
        .AW    (AW)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (dec_we && in_acc),
        .i_waddr (dec_waddr),
        .i_wdata (b),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign name_last = ((LW'(r_idx) + LW'(1)) == r_name_len);
    assign emit_last = r_pend_val ? !(r_pend_pair || r_pend_line)
                     : (r_pend_pair ? !r_pend_line : 1'b1);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            kvtp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (n_replay) begin
                        n_state = kvtp_pkg::ST_RD;
                    end else if (n_pend_val || n_pend_pair || n_pend_line) begin
                        n_state = kvtp_pkg::ST_EMIT;
                    end
                end
            end
            kvtp_pkg::ST_EMIT: begin
                if (can_load && emit_last) begin
                    n_state = kvtp_pkg::ST_IDLE;
                end
            end
            kvtp_pkg::ST_RD: begin
                n_state = kvtp_pkg::ST_WAIT;
            end
            kvtp_pkg::ST_WAIT: begin
                if (can_load) begin
                    n_state = name_last ? kvtp_pkg::ST_IDLE : kvtp_pkg::ST_RD;
                end
            end
            default: begin
                n_state = kvtp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        load_kind  = kvtp_pkg::KIND_LINE_END;
        load_char  = '0;
        load_last  = 1'b0;
        rd_en      = 1'b0;
        clr_val    = 1'b0;
        clr_pair   = 1'b0;
        case (r_state)
            kvtp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            kvtp_pkg::ST_EMIT: begin
                load_out  = can_load;
                load_last = emit_last;
                if (r_pend_val) begin
                    load_kind = kvtp_pkg::KIND_VALUE;
                    load_char = r_pend_char;
                    clr_val   = can_load;
                end else if (r_pend_pair) begin
                    load_kind = kvtp_pkg::KIND_PAIR_END;
                    clr_pair  = can_load;
                end
            end
            kvtp_pkg::ST_RD: begin
                rd_en = 1'b1;
            end
            kvtp_pkg::ST_WAIT: begin
                load_out  = can_load;
                load_kind = kvtp_pkg::KIND_NAME;
                load_char = ram_rdata;
                load_last = name_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Parser and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kvtp_pkg::ST_IDLE;
            r_phase     <= kvtp_pkg::PH_SKIP;
            r_esc       <= 1'b0;
            r_name_len  <= '0;
            r_val_len   <= '0;
            r_pair      <= 1'b0;
            r_pend_val  <= 1'b0;
            r_pend_pair <= 1'b0;
            r_pend_line <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_phase     <= n_phase;
                r_esc       <= n_esc;
                r_name_len  <= n_name_len;
                r_val_len   <= n_val_len;
                r_pair      <= n_pair;
                r_pend_val  <= n_pend_val;
                r_pend_pair <= n_pend_pair;
                r_pend_line <= n_pend_line;
                r_idx       <= '0;
            end else begin
                if (clr_val) begin
                    r_pend_val <= 1'b0;
                end
                if (clr_pair) begin
                    r_pend_pair <= 1'b0;
                end
                if (load_out && (r_state == kvtp_pkg::ST_EMIT) && emit_last) begin
                    r_pend_line <= 1'b0;
                end
                if (load_out && (r_state == kvtp_pkg::ST_WAIT) && !name_last) begin
                    r_idx <= r_idx + AW'(1);
                end
            end
        end
    end

    // Pending character payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend_char <= n_pend_char;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_kind <= load_kind;
            r_out_char <= load_char;
            r_out_last <= load_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

`ifndef SYNTHESIS
    // The stored name never grows past its capacity.
    a_name_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_len <= LW'(NAME_CAP - 1))
        else $error("name length beyond capacity");

    // Byte 0 always returns the parser to the blank-skipping phase, clean.
    a_nul_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_byte == kvtp_pkg::CH_NUL)) |=>
        ((r_phase == kvtp_pkg::PH_SKIP) && !r_esc && !r_pair && r_pend_line))
        else $error("byte 0 did not end the line");

    // A line end is always the last word of its byte.
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_kind == kvtp_pkg::KIND_LINE_END)) |-> o_out_last)
        else $error("line end not marked last");

    // Replay reads only entries written for the current name.
    a_replay_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvtp_pkg::ST_RD) |-> (LW'(r_idx) < r_name_len))
        else $error("replay index past stored name");

    // Kinds without a character carry zero.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_kind == kvtp_pkg::KIND_PAIR_END) ||
                         (o_out_kind == kvtp_pkg::KIND_LINE_END))) |->
        (o_out_char == kvtp_pkg::CH_NUL))
        else $error("marker word carries a character");
`endif

endmodule

`default_nettype wire

>>> test/key_value_token_parser_tb.sv
`default_nettype none

module key_value_token_parser_tb;

    localparam int NAME_CAP    = kvtp_pkg::NAME_CAP_DEF;
    localparam int VALUE_CAP   = kvtp_pkg::VALUE_CAP_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * NAME_CAP + 8;

    typedef struct packed {
        kvtp_pkg::t_kind kind;
        logic [7:0]      ch;
        logic            last;
    } t_word;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_char;
    logic       o_out_last;

    key_value_token_parser #(
        .NAME_CAP  (NAME_CAP),
        .VALUE_CAP (VALUE_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_kind  (o_out_kind),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Tokenizer state mirrored by the predictor.
    kvtp_pkg::t_phase tok_phase;
    logic             tok_escape;
    logic [7:0]       name_chars [NAME_CAP-1];
    int               name_len;
    int               value_len;
    logic             pair_open;

    // Words caused by the byte being predicted, and all words still owed.
    t_word      byte_words [$];
    t_word      pending_words [$];
    logic [7:0] line_buf [$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int bytes_sent    = 0;
    int words_checked = 0;
    int lines_ended   = 0;

    // Predictor: expected words for one accepted byte.
    function automatic void emit_word(kvtp_pkg::t_kind k, logic [7:0] c);
        t_word w;
        w.kind = k;
        w.ch   = c;
        w.last = 1'b0;
        byte_words.push_back(w);
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return b == kvtp_pkg::CH_SPACE || b == kvtp_pkg::CH_TAB;
    endfunction

    function automatic void put_value_char(logic [7:0] c);
        if (pair_open && value_len < VALUE_CAP - 1) begin
            emit_word(kvtp_pkg::KIND_VALUE, c);
            value_len++;
        end
    endfunction

    function automatic void close_pair();
        if (pair_open)
            emit_word(kvtp_pkg::KIND_PAIR_END, 8'h00);
        pair_open  = 1'b0;
        tok_escape = 1'b0;
    endfunction

    function automatic void close_line();
        emit_word(kvtp_pkg::KIND_LINE_END, 8'h00);
        tok_phase  = kvtp_pkg::PH_SKIP;
        tok_escape = 1'b0;
        pair_open  = 1'b0;
        lines_ended++;
    endfunction

    function automatic void replay_name();
        for (int i = 0; i < name_len; i++)
            emit_word(kvtp_pkg::KIND_NAME, name_chars[i]);
        pair_open  = name_len > 0;
        value_len  = 0;
        tok_escape = 1'b0;
        tok_phase  = kvtp_pkg::PH_AFTER_EQ;
    endfunction

    function automatic void decode_value(logic [7:0] b);
        logic quoted;
        quoted = tok_phase == kvtp_pkg::PH_QUOTED;
        if (tok_escape) begin
            tok_escape = 1'b0;
            if (b == kvtp_pkg::CH_NUL) begin
                // A backslash right before the end stands for itself.
                put_value_char(kvtp_pkg::CH_BSLASH);
                close_pair();
                close_line();
            end else if (b == kvtp_pkg::CH_LC_N) begin
                put_value_char(kvtp_pkg::CH_NL);
            end else if (b == kvtp_pkg::CH_LC_T) begin
                put_value_char(kvtp_pkg::CH_TAB);
            end else if (b == kvtp_pkg::CH_LC_R) begin
                put_value_char(kvtp_pkg::CH_CR);
            end else begin
                put_value_char(b);
            end
        end else if (b == kvtp_pkg::CH_NUL) begin
            close_pair();
            close_line();
        end else if (b == kvtp_pkg::CH_BSLASH) begin
            tok_escape = 1'b1;
        end else if ((quoted && b == kvtp_pkg::CH_QUOTE) || (!quoted && is_blank(b))) begin
            close_pair();
            tok_phase = kvtp_pkg::PH_SKIP;
        end else begin
            put_value_char(b);
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] b);
        t_word w;
        case (tok_phase)
            kvtp_pkg::PH_SKIP: begin
                if (b == kvtp_pkg::CH_NUL) begin
                    close_line();
                end else if (is_blank(b)) begin
                end else if (b == kvtp_pkg::CH_EQ) begin
                    name_len = 0;
                    replay_name();
                end else begin
                    name_chars[0] = b;
                    name_len      = 1;
                    tok_phase     = kvtp_pkg::PH_NAME;
                end
            end
            kvtp_pkg::PH_NAME: begin
                if (b == kvtp_pkg::CH_NUL) begin
                    close_line();
                end else if (is_blank(b)) begin
                    tok_phase = kvtp_pkg::PH_SKIP;
                end else if (b == kvtp_pkg::CH_EQ) begin
                    replay_name();
                end else if (name_len < NAME_CAP - 1) begin
                    name_chars[name_len] = b;
                    name_len++;
                end
            end
            kvtp_pkg::PH_AFTER_EQ: begin
                if (is_blank(b)) begin
                end else if (b == kvtp_pkg::CH_QUOTE) begin
                    tok_phase = kvtp_pkg::PH_QUOTED;
                end else begin
                    tok_phase = kvtp_pkg::PH_VALUE;
                    decode_value(b);
                end
            end
            kvtp_pkg::PH_VALUE, kvtp_pkg::PH_QUOTED: begin
                decode_value(b);
            end
            default: begin
                tok_phase  = kvtp_pkg::PH_SKIP;
                tok_escape = 1'b0;
            end
        endcase
        // The final word of this byte carries the last flag.
        for (int i = 0; i < byte_words.size(); i++) begin
            w      = byte_words[i];
            w.last = (i == byte_words.size() - 1);
            pending_words.push_back(w);
        end
        byte_words.delete();
    endfunction

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycle_count, pending_words.size());
            $display("key_value_token_parser test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Compare each accepted word with the oldest expected one.
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("cycle %0d: unexpected word kind %0d char %02h last %0b",
                             cycle_count, o_out_kind, o_out_char, o_out_last);
            end else begin
                want = pending_words.pop_front();
                if (o_out_kind !== want.kind || o_out_char !== want.ch
                        || o_out_last !== want.last) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $write("cycle %0d: expected kind %0d char %02h last %0b,",
                               cycle_count, want.kind, want.ch, want.last);
                        $display(" got kind %0d char %02h last %0b",
                                 o_out_kind, o_out_char, o_out_last);
                    end
                end
            end
        end
    end

    // Offer one byte, with random idle cycles first, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tokenize_byte(b);
        bytes_sent++;
    endtask

    task automatic send_line();
        while (line_buf.size() != 0)
            send_byte(line_buf.pop_front());
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic wait_all_words();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Random byte, mostly lowercase letters.
    function automatic logic [7:0] rand_char();
        if ($urandom_range(99) < 70)
            return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick_name_char();
        logic [7:0] c;
        c = rand_char();
        while (is_blank(c) || c == kvtp_pkg::CH_EQ)
            c = rand_char();
        return c;
    endfunction

    task automatic add_name(input int len);
        for (int i = 0; i < len; i++)
            line_buf.push_back(pick_name_char());
    endtask

    // One value character, sometimes as an escape sequence.
    task automatic add_value_char(input logic quoted);
        logic [7:0] c;
        int         roll;
        if ($urandom_range(99) < 12) begin
            line_buf.push_back(kvtp_pkg::CH_BSLASH);
            roll = $urandom_range(5);
            case (roll)
                0: c = kvtp_pkg::CH_LC_N;
                1: c = kvtp_pkg::CH_LC_T;
                2: c = kvtp_pkg::CH_LC_R;
                3: c = kvtp_pkg::CH_QUOTE;
                4: c = kvtp_pkg::CH_BSLASH;
                default: c = 8'($urandom_range(1, 255));
            endcase
            line_buf.push_back(c);
        end else begin
            c = rand_char();
            while (c == kvtp_pkg::CH_BSLASH ||
                   (quoted ? c == kvtp_pkg::CH_QUOTE : is_blank(c)))
                c = rand_char();
            line_buf.push_back(c);
        end
    endtask

    task automatic add_value(input int len, input logic quoted);
        for (int i = 0; i < len; i++)
            add_value_char(quoted);
    endtask

    // Mostly well-formed lines with random content; some pure noise.
    task automatic build_random_line();
        int   n_tok;
        int   roll;
        int   len;
        logic quoted;
        if ($urandom_range(99) < 12) begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
                line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(kvtp_pkg::CH_NUL);
            return;
        end
        n_tok = $urandom_range(1, 4);
        for (int t = 0; t < n_tok; t++) begin
            repeat ($urandom_range(0, 2))
                line_buf.push_back($urandom_range(1) ? kvtp_pkg::CH_SPACE
                                                     : kvtp_pkg::CH_TAB);
            roll = $urandom_range(99);
            if (roll < 10) begin
                // A bare word without '=' is dropped.
                add_name($urandom_range(1, 5));
                line_buf.push_back(kvtp_pkg::CH_SPACE);
            end else begin
                if (roll >= 18)
                    add_name(roll >= 96 ? $urandom_range(32, 36) : $urandom_range(1, 6));
                line_buf.push_back(kvtp_pkg::CH_EQ);
                repeat ($urandom_range(0, 1))
                    line_buf.push_back(kvtp_pkg::CH_SPACE);
                quoted = $urandom_range(99) < 35;
                if (quoted)
                    line_buf.push_back(kvtp_pkg::CH_QUOTE);
                len = ($urandom_range(99) < 2) ? $urandom_range(125, 132)
                                               : $urandom_range(0, 8);
                add_value(len, quoted);
                if (quoted && $urandom_range(99) < 90) begin
                    line_buf.push_back(kvtp_pkg::CH_QUOTE);
                    if ($urandom_range(1))
                        line_buf.push_back(kvtp_pkg::CH_SPACE);
                end else begin
                    line_buf.push_back(kvtp_pkg::CH_SPACE);
                end
            end
        end
        if ($urandom_range(99) < 8)
            line_buf.push_back(kvtp_pkg::CH_BSLASH);
        line_buf.push_back(kvtp_pkg::CH_NUL);
    endtask

    // Escapes, quoting, empty names and values, bare tokens, line ends.
    task automatic test_directed();
        add_text(" \tk=\"\\n\\t\\r\\");
        line_buf.push_back(8'hFF);
        add_text("\"v=a\"\\");
        line_buf.push_back(kvtp_pkg::CH_NUL);
        add_text("x =y e= ");
        line_buf.push_back(kvtp_pkg::CH_NUL);
        add_text("q=\"z");
        line_buf.push_back(kvtp_pkg::CH_NUL);
        add_text("tok");
        line_buf.push_back(kvtp_pkg::CH_NUL);
        send_line();
        wait_all_words();
    endtask

    // Name and value truncation, and the longest name replay.
    task automatic test_capacity();
        add_name(NAME_CAP + 3);
        add_text("=v ");
        add_text("w=");
        add_value(VALUE_CAP + 2, 1'b0);
        line_buf.push_back(kvtp_pkg::CH_NUL);
        send_line();
        wait_all_words();
    endtask

    // Receiver holds off while the sender keeps offering bytes.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle  = in_idle_pct;
        in_idle_pct = 0;
        hold_left   = 300;
        add_name(NAME_CAP - 1);
        line_buf.push_back(kvtp_pkg::CH_EQ);
        add_value(4, 1'b0);
        line_buf.push_back(kvtp_pkg::CH_SPACE);
        line_buf.push_back(kvtp_pkg::CH_NUL);
        send_line();
        wait_all_words();
        in_idle_pct = saved_idle;
    endtask

    task automatic test_random(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            build_random_line();
            send_line();
        end
        wait_all_words();
    endtask

    initial begin
        tok_phase  = kvtp_pkg::PH_SKIP;
        tok_escape = 1'b0;
        name_len   = 0;
        value_len  = 0;
        pair_open  = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct   = 28;
        out_stall_pct = 80;
        test_directed();
        test_capacity();
        test_random(10);

        in_idle_pct   = 80;
        out_stall_pct = 28;
        test_backpressure();
        test_random(10);

        in_idle_pct   = 0;
        out_stall_pct = 0;
        test_random(10);

        wait_all_words();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d bytes over %0d command lines, %0d output words checked.",
                 bytes_sent, lines_ended, words_checked);
        $display("Included escapes, quoting, truncation and a long output stall.");
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("key_value_token_parser test passed");
        end else begin
            $display("%0d mismatches, %0d words missing", error_count,
                     pending_words.size());
            $display("key_value_token_parser test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/kvtp_pkg.sv
rtl/core/kvtp_name_ram.sv
rtl/core/key_value_token_parser.sv
test/key_value_token_parser_tb.sv
